// ===== hdl/dens_pkg.sv =====
// ----------------------------------------------------------------------------
// dens_pkg
// Shared types and constants for the directory entry name scanner.
// ----------------------------------------------------------------------------
package dens_pkg;

    // Stream and name limits
    localparam int MAX_NAME_BYTES = 32;
    localparam int MAX_DIR_BYTES  = 4096;
    localparam int COUNT_W        = $clog2(MAX_DIR_BYTES + 1);

    // Record header layout
    localparam int HDR_BYTES   = 8;
    localparam int INODE_BYTES = 4;
    localparam int NLEN_POS    = 6;

    // Query storage: four 64-bit words, byte 0 in the low bits
    localparam int QWORDS    = 4;
    localparam int QWORD_W   = 64;
    localparam int QBYTES    = QWORDS * QWORD_W / 8;
    localparam int QIDX_W    = $clog2(QBYTES);
    localparam int QLEN_W    = 6;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_WORD0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_WORD1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_WORD2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_WORD3  = 3'd4;

    // Scan status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NO_MATCH  = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN  = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef struct packed {
        logic [QLEN_W-1:0]       len;
        logic [QBYTES*8-1:0]     bytes;
    } t_query;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] inode;
    } t_result;

endpackage

// ===== hdl/dens_record_parser.sv =====
// ----------------------------------------------------------------------------
// dens_record_parser
// Per-byte record walker: header capture, record checks, name compare and
// the scan decision. Emits one result on the last byte and clears itself.
// ----------------------------------------------------------------------------
module dens_record_parser import dens_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_query        i_query,
    input  logic          i_take,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output logic          o_res_valid,
    output t_result       o_res
);

    logic [COUNT_W-1:0] r_stream_count, n_stream_count;
    logic [15:0]        r_record_pos, n_record_pos;
    logic [15:0]        r_record_length, n_record_length;
    logic [7:0]         r_name_length, n_name_length;
    logic [31:0]        r_inode_acc, n_inode_acc;
    logic               r_name_equal, n_name_equal;
    logic               r_scan_decided, n_scan_decided;
    logic [1:0]         r_outcome, n_outcome;
    logic [31:0]        r_match_inode, n_match_inode;

    logic [8:0]         name_end;
    logic               candidate;
    logic [15:0]        qidx;
    logic [7:0]         qbyte;
    logic [16:0]        pos_inc;
    logic               stop;
    logic               eq;

    // Record-level terms
    assign name_end  = {1'b0, r_name_length} + 9'(HDR_BYTES);
    assign candidate = (r_inode_acc != '0)
                    && ({2'b00, i_query.len} <= 8'(MAX_NAME_BYTES))
                    && ({2'b00, i_query.len} == r_name_length);
    assign qidx      = r_record_pos - 16'(HDR_BYTES);
    assign qbyte     = (qidx[15:QIDX_W] == '0) ? i_query.bytes[qidx[QIDX_W-1:0]*8 +: 8] : 8'd0;
    assign pos_inc   = {1'b0, r_record_pos} + 17'd1;

    // Next-state for one accepted byte
    always_comb begin
        n_stream_count  = r_stream_count;
        n_record_pos    = r_record_pos;
        n_record_length = r_record_length;
        n_name_length   = r_name_length;
        n_inode_acc     = r_inode_acc;
        n_name_equal    = r_name_equal;
        n_scan_decided  = r_scan_decided;
        n_outcome       = r_outcome;
        n_match_inode   = r_match_inode;
        stop            = 1'b0;
        eq              = r_name_equal;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (i_take && (r_stream_count < COUNT_W'(MAX_DIR_BYTES))) begin
            n_stream_count = r_stream_count + 1'b1;
            if (!r_scan_decided) begin
                if (r_record_pos < 16'(INODE_BYTES)) begin
                    n_inode_acc = r_inode_acc | ({24'd0, i_data_byte} << {r_record_pos[1:0], 3'b000});
                end else if (r_record_pos == 16'(INODE_BYTES)) begin
                    n_record_length = {8'd0, i_data_byte};
                end else if (r_record_pos == 16'(INODE_BYTES + 1)) begin
                    n_record_length = r_record_length | {i_data_byte, 8'd0};
                end else if (r_record_pos == 16'(NLEN_POS)) begin
                    n_name_length = i_data_byte;
                end else if (r_record_pos == 16'(HDR_BYTES - 1)) begin
                    // header complete: checks come before matching
                    if (r_record_length == '0) begin
                        stop = 1'b1;
                        n_scan_decided = 1'b1;
                        n_outcome = ST_ZERO_LEN;
                    end else if (r_record_length < {7'd0, name_end}) begin
                        stop = 1'b1;
                        n_scan_decided = 1'b1;
                        n_outcome = ST_MALFORMED;
                    end else if (candidate && (r_name_length == '0)) begin
                        stop = 1'b1;
                        n_scan_decided = 1'b1;
                        n_outcome = ST_FOUND;
                        n_match_inode = r_inode_acc;
                    end
                end else if (r_record_pos < {7'd0, name_end}) begin
                    // name byte
                    if (i_data_byte != qbyte) begin
                        eq = 1'b0;
                    end
                    n_name_equal = eq;
                    if ((pos_inc == {8'd0, name_end}) && candidate && eq) begin
                        stop = 1'b1;
                        n_scan_decided = 1'b1;
                        n_outcome = ST_FOUND;
                        n_match_inode = r_inode_acc;
                    end
                end

                // advance, or wrap to the next record
                if (!stop) begin
                    if ((r_record_pos >= 16'(HDR_BYTES - 1))
                        && (pos_inc >= {1'b0, r_record_length})) begin
                        n_record_pos    = '0;
                        n_record_length = '0;
                        n_name_length   = '0;
                        n_inode_acc     = '0;
                        n_name_equal    = 1'b1;
                    end else begin
                        n_record_pos = pos_inc[15:0];
                    end
                end
            end
        end

        // Last byte: report, then back to the cleared scan state
        if (i_take && i_last_byte) begin
            o_res_valid     = 1'b1;
            o_res.status    = n_outcome;
            o_res.inode     = (n_outcome == ST_FOUND) ? n_match_inode : 32'd0;
            n_stream_count  = '0;
            n_record_pos    = '0;
            n_record_length = '0;
            n_name_length   = '0;
            n_inode_acc     = '0;
            n_name_equal    = 1'b1;
            n_scan_decided  = 1'b0;
            n_outcome       = ST_NO_MATCH;
            n_match_inode   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_count  <= '0;
            r_record_pos    <= '0;
            r_record_length <= '0;
            r_name_length   <= '0;
            r_inode_acc     <= '0;
            r_name_equal    <= 1'b1;
            r_scan_decided  <= 1'b0;
            r_outcome       <= ST_NO_MATCH;
            r_match_inode   <= '0;
        end else begin
            r_stream_count  <= n_stream_count;
            r_record_pos    <= n_record_pos;
            r_record_length <= n_record_length;
            r_name_length   <= n_name_length;
            r_inode_acc     <= n_inode_acc;
            r_name_equal    <= n_name_equal;
            r_scan_decided  <= n_scan_decided;
            r_outcome       <= n_outcome;
            r_match_inode   <= n_match_inode;
        end
    end

`ifndef ASSERT_OFF
    // an undecided scan always reads as no match
    a_undecided_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_scan_decided |-> (r_outcome == ST_NO_MATCH))
        else $error("undecided scan with outcome other than no match");

    // a reported inode is zero unless the record was found
    a_inode_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ((o_res.status == ST_FOUND) || (o_res.inode == 32'd0)))
        else $error("non-zero inode reported without a match");
`endif

endmodule

// ===== hdl/dens_out_buf.sv =====
// ----------------------------------------------------------------------------
// dens_out_buf
// Two-entry result buffer: an output register plus a skid register, so the
// input side keeps taking beats while a result waits downstream.
// ----------------------------------------------------------------------------
module dens_out_buf import dens_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_push_res;
            end else begin
                r_out <= i_push_res;
            end
        end
    end

`ifndef ASSERT_OFF
    // the skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // no push lands while both entries are full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into a full buffer");
`endif

endmodule

// ===== hdl/dir_entry_name_scanner.sv =====
// ----------------------------------------------------------------------------
// dir_entry_name_scanner
// Linear directory lookup over a byte stream: finds the first live record
// whose name equals the configured query and reports status and inode.
// ----------------------------------------------------------------------------
// One directory byte is taken per beat, one beat per cycle sustained: each
// byte updates the record walker's counters and name compare in the cycle it
// is accepted. The beat marked last yields one result beat (status and inode)
// registered into a two-entry output buffer; input stalls only when
// both entries hold results not yet taken. Query registers may be written
// whenever no scan is in progress; configuration writes complete at once.
module dir_entry_name_scanner import dens_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // directory byte stream
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    // result
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_scan_status,
    output logic [31:0]          o_entry_inode,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [QWORD_W-1:0]   i_cfg_data
);

    t_query  r_query;
    logic    take;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    buf_full;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !buf_full;
    assign take        = i_valid && !buf_full;

    // query register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_QUERY_LENGTH: r_query.len <= i_cfg_data[QLEN_W-1:0];
                CFG_QUERY_WORD0:  r_query.bytes[0*QWORD_W +: QWORD_W] <= i_cfg_data;
                CFG_QUERY_WORD1:  r_query.bytes[1*QWORD_W +: QWORD_W] <= i_cfg_data;
                CFG_QUERY_WORD2:  r_query.bytes[2*QWORD_W +: QWORD_W] <= i_cfg_data;
                CFG_QUERY_WORD3:  r_query.bytes[3*QWORD_W +: QWORD_W] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dens_record_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_query     (r_query),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dens_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_push_res (res),
        .o_full     (buf_full),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_scan_status = out_res.status;
    assign o_entry_inode = out_res.inode;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the directory entry name scanner. Directory bytes
// are streamed as records laid end to end and every lookup result is checked
// against a cycle-free model of the record walk kept in this bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dens_pkg::*;

    // DUT ports
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_last_byte = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [1:0]           o_scan_status;
    logic [31:0]          o_entry_inode;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_QUERY_LENGTH;
    logic [QWORD_W-1:0]   i_cfg_data  = '0;

    dir_entry_name_scanner dut (.*);

    // Directed beat table row
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_result    want;
    } t_beat_row;

    t_beat_row  directed_rows[$];
    t_result    lookup_due[$];
    t_result    due_now;
    logic [7:0] stream_buf[$];
    int         stream_keep;
    int         check_errors   = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    // Query copy as seen by the walker model
    logic [QLEN_W-1:0]   q_len   = '0;
    logic [QBYTES*8-1:0] q_bytes = '0;

    // Walker model state
    logic [COUNT_W-1:0] stream_count = '0;
    logic [15:0]        rec_pos      = '0;
    logic [15:0]        rec_len      = '0;
    logic [7:0]         entry_nlen   = '0;
    logic [31:0]        inode_acc    = '0;
    logic               name_eq      = 1'b1;
    logic               scan_done    = 1'b0;
    logic [1:0]         scan_outcome = ST_NO_MATCH;
    logic [31:0]        found_inode  = '0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Record walk model
    // ------------------------------------------------------------------
    function automatic logic [7:0] query_at(input int unsigned i);
        if (i < QBYTES)
            return q_bytes[i*8 +: 8];
        return 8'h00;
    endfunction

    function automatic bit is_candidate();
        return inode_acc != 32'd0 && q_len <= MAX_NAME_BYTES && entry_nlen == q_len;
    endfunction

    function automatic void settle(input logic [1:0] code);
        scan_done    = 1'b1;
        scan_outcome = code;
        if (code == ST_FOUND)
            found_inode = inode_acc;
    endfunction

    function automatic void walk_byte(input logic [7:0] b);
        int unsigned pos;
        int unsigned name_end;
        pos      = rec_pos;
        name_end = HDR_BYTES + entry_nlen;
        if (pos < INODE_BYTES) begin
            inode_acc[pos*8 +: 8] = b;
        end else if (pos == INODE_BYTES) begin
            rec_len = {8'h00, b};
        end else if (pos == INODE_BYTES + 1) begin
            rec_len[15:8] = b;
        end else if (pos == NLEN_POS) begin
            entry_nlen = b;
        end else if (pos == HDR_BYTES - 1) begin
            // header complete: length checks come before any match
            if (rec_len == 16'd0) begin
                settle(ST_ZERO_LEN);
                return;
            end
            if (rec_len < name_end) begin
                settle(ST_MALFORMED);
                return;
            end
            if (is_candidate() && entry_nlen == 8'd0) begin
                settle(ST_FOUND);
                return;
            end
        end else if (pos < name_end) begin
            if (b != query_at(pos - HDR_BYTES))
                name_eq = 1'b0;
            if (pos + 1 == name_end && is_candidate() && name_eq) begin
                settle(ST_FOUND);
                return;
            end
        end
        // step to the next record once its length is used up
        if (pos >= HDR_BYTES - 1 && pos + 1 >= rec_len) begin
            rec_pos    = '0;
            rec_len    = '0;
            entry_nlen = '0;
            inode_acc  = '0;
            name_eq    = 1'b1;
        end else begin
            rec_pos = 16'(pos + 1);
        end
    endfunction

    // One accepted beat; returns 1 with the lookup result on the last byte
    function automatic bit dir_walk_beat(input logic [7:0] b, input logic last,
                                         output t_result res);
        if (stream_count < MAX_DIR_BYTES) begin
            stream_count++;
            if (!scan_done)
                walk_byte(b);
        end
        res.status = scan_outcome;
        res.inode  = (scan_outcome == ST_FOUND) ? found_inode : 32'd0;
        if (last) begin
            stream_count = '0;
            rec_pos      = '0;
            rec_len      = '0;
            entry_nlen   = '0;
            inode_acc    = '0;
            name_eq      = 1'b1;
            scan_done    = 1'b0;
            scan_outcome = ST_NO_MATCH;
            found_inode  = '0;
        end
        return last;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and in-order compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (lookup_due.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d inode %h",
                         $time, o_scan_status, o_entry_inode);
                check_errors++;
            end else begin
                due_now = lookup_due.pop_front();
                if (o_scan_status !== due_now.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, due_now.status, o_scan_status);
                    check_errors++;
                end
                if (o_entry_inode !== due_now.inode) begin
                    $display("%0t: inode mismatch: expected %h actual %h",
                             $time, due_now.inode, o_entry_inode);
                    check_errors++;
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [QWORD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_QUERY_LENGTH: q_len = val[QLEN_W-1:0];
            CFG_QUERY_WORD0:  q_bytes[63:0]    = val;
            CFG_QUERY_WORD1:  q_bytes[127:64]  = val;
            CFG_QUERY_WORD2:  q_bytes[191:128] = val;
            CFG_QUERY_WORD3:  q_bytes[255:192] = val;
            default: ;
        endcase
    endtask

    task automatic set_query(input logic [QLEN_W-1:0] len, input logic [63:0] w0,
                             input logic [63:0] w1, input logic [63:0] w2,
                             input logic [63:0] w3);
        cfg_write(CFG_QUERY_LENGTH, {58'd0, len});
        cfg_write(CFG_QUERY_WORD0, w0);
        cfg_write(CFG_QUERY_WORD1, w1);
        cfg_write(CFG_QUERY_WORD2, w2);
        cfg_write(CFG_QUERY_WORD3, w3);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one directory byte; the model result or a typed one is queued
    task automatic send_beat(input logic [7:0] d, input logic last, input logic typed,
                             input t_result typed_res);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        if (dir_walk_beat(d, last, res))
            lookup_due.push_back(typed ? typed_res : res);
    endtask

    task automatic send_stream();
        t_result none;
        int      k;
        none = '0;
        for (k = 0; k < stream_keep; k++)
            send_beat(stream_buf[k], k == stream_keep - 1, 1'b0, none);
    endtask

    // Wait until every lookup result is back and the block is quiet
    task automatic drain();
        i_valid <= 1'b0;
        while (lookup_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
            3:       begin send_idle_pct = 16; recv_stall_pct = 16; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Record builders
    // ------------------------------------------------------------------
    task automatic put_record(input logic [31:0] ino, input logic [15:0] rlen,
                              input logic [7:0] nlen, input int pad,
                              input bit flip, input bit rnd);
        int k;
        int bad;
        bad = flip ? int'($urandom_range(nlen - 1)) : -1;
        for (k = 0; k < INODE_BYTES; k++)
            stream_buf.push_back(ino[k*8 +: 8]);
        stream_buf.push_back(rlen[7:0]);
        stream_buf.push_back(rlen[15:8]);
        stream_buf.push_back(nlen);
        stream_buf.push_back(8'($urandom));
        // name: query bytes, one bit off in a flipped name, or random
        for (k = 0; k < nlen; k++)
            stream_buf.push_back(rnd ? 8'($urandom) :
                (query_at(k) ^ ((k == bad) ? 8'(1 << $urandom_range(7)) : 8'h00)));
        repeat (pad) stream_buf.push_back(8'($urandom));
    endtask

    task automatic put_random_record();
        int          sel;
        int          pad;
        logic [31:0] ino;
        logic [7:0]  nlen;
        logic [15:0] rlen;
        bit          flip;
        bit          rnd;
        sel  = $urandom_range(99);
        ino  = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
        if (ino == 32'd0)
            ino = 32'd1;
        nlen = {2'b00, q_len};
        flip = ($urandom_range(2) == 0) && nlen != 8'd0;
        rnd  = 1'b0;
        pad  = $urandom_range(0, 3);
        // non-candidates: dead inode or name length off the query
        if (sel >= 55 && sel < 70) begin
            if ($urandom_range(1))
                ino = 32'd0;
            else
                nlen = 8'($urandom_range(0, 40));
            rnd = 1'($urandom_range(1));
        end
        rlen = 16'(HDR_BYTES + nlen + pad);
        if (sel >= 70 && sel < 80) begin
            rlen = 16'd0;
        end else if (sel >= 80 && sel < 90) begin
            rlen = 16'($urandom_range(1, HDR_BYTES + nlen - 1));
        end else if (sel >= 90) begin
            // long records: padding to skip, or a length running past the stream
            if ($urandom_range(3) == 0) begin
                rlen = 16'hFFFF;
            end else begin
                pad  = $urandom_range(4, 20);
                rlen = 16'(HDR_BYTES + nlen + pad);
            end
        end
        put_record(ino, rlen, nlen, pad, flip, rnd);
    endtask

    // Mostly record sequences, some cut short, some plain noise
    task automatic build_stream();
        int n;
        stream_buf.delete();
        if ($urandom_range(99) < 10) begin
            n = $urandom_range(1, 16);
            repeat (n) stream_buf.push_back(8'($urandom));
            stream_keep = n;
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) put_random_record();
            stream_keep = stream_buf.size();
            if ($urandom_range(99) < 15)
                stream_keep = $urandom_range(1, stream_buf.size() - 1);
        end
    endtask

    task automatic run_phase(input logic [QLEN_W-1:0] len, input logic [63:0] w0,
                             input logic [63:0] w1, input logic [63:0] w2,
                             input logic [63:0] w3, input int mode);
        int beats;
        drain();
        set_query(len, w0, w1, w2, w3);
        set_idling(mode);
        beats = 0;
        while (beats < 110) begin
            build_stream();
            send_stream();
            beats += stream_keep;
        end
    endtask

    task automatic add_row(input logic [7:0] d, input logic last, input logic typed,
                           input logic [1:0] status, input logic [31:0] inode);
        t_beat_row r;
        r.data        = d;
        r.last        = last;
        r.typed       = typed;
        r.want.status = status;
        r.want.inode  = inode;
        directed_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int waited;
        int k;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, reset query (empty name)
        // header cut off after one byte
        add_row(8'h00, 1, 1, ST_NO_MATCH, 32'd0);
        // zero record length
        add_row(8'h01, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0);
        add_row(8'h00, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0);
        add_row(8'h00, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0);
        add_row(8'h00, 0, 0, 0, 0);
        add_row(8'h00, 1, 1, ST_ZERO_LEN, 32'd0);
        // empty name matches the empty query, all-ones inode
        add_row(8'hFF, 0, 0, 0, 0); add_row(8'hFF, 0, 0, 0, 0);
        add_row(8'hFF, 0, 0, 0, 0); add_row(8'hFF, 0, 0, 0, 0);
        add_row(8'h08, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0);
        add_row(8'h00, 0, 0, 0, 0);
        add_row(8'hFF, 1, 1, ST_FOUND, 32'hFFFF_FFFF);
        // record too short for its name, dead inode
        add_row(8'h00, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0);
        add_row(8'h00, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0);
        add_row(8'h07, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0);
        add_row(8'h05, 0, 0, 0, 0);
        add_row(8'h00, 1, 1, ST_MALFORMED, 32'd0);

        for (k = 0; k < directed_rows.size(); k++)
            send_beat(directed_rows[k].data, directed_rows[k].last,
                      directed_rows[k].typed, directed_rows[k].want);

        // Random record streams over several query settings and idling modes
        run_phase(6'd0, 64'd0, 64'd0, 64'd0, 64'd0, 0);
        run_phase(6'd32, '1, '1, '1, '1, 1);
        run_phase(6'd1, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 2);
        run_phase(6'd63, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 3);
        run_phase(6'd33, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 0);
        run_phase(6'($urandom_range(2, 12)), {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 1);
        run_phase(6'($urandom_range(2, 12)), {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 2);
        run_phase(6'($urandom_range(2, 12)), {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 3);
        run_phase(6'd31, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 0);

        // Wind down
        i_valid <= 1'b0;
        waited = 0;
        while (lookup_due.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (lookup_due.size() != 0) begin
            $display("%0t: %0d lookup results never arrived", $time, lookup_due.size());
            check_errors++;
        end
        if (check_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
